// ===== design/gsma_pkg.sv =====
// Shared types, codes and constants for the gain-scaled mix accumulator.
`timescale 1ns / 1ps

package gsma_pkg;

    // Default geometry of the mix buffer
    localparam int BUFFER_SIZE_DEF = 4096;
    localparam int CHANNELS_DEF    = 2;

    // Field widths
    localparam int POSITION_W = 12;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int MASK_W     = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // Scaling: two Q2.14 gains give 28 fraction bits
    localparam int GAIN_FRAC_W = 28;
    localparam int PROD1_W     = SAMPLE_W + GAIN_W;
    localparam int PROD2_W     = PROD1_W + GAIN_W;
    localparam int SCALED_W    = PROD2_W - GAIN_FRAC_W + 1;
    localparam int SUM_W       = SCALED_W + 1;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd16384;

    localparam logic signed [SUM_W-1:0] SLOT_MAX = 22'sd32767;
    localparam logic signed [SUM_W-1:0] SLOT_MIN = -22'sd32768;

    // Command codes
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ACCUM = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME_ENABLE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MASTER_VOLUME = 1'b1;

    // Input beat
    typedef struct packed {
        cmd_t                        command;
        logic [POSITION_W-1:0]       position;
        logic signed [SAMPLE_W-1:0]  sample_in;
        logic [GAIN_W-1:0]           envelope_gain;
        logic [MASK_W-1:0]           channel_mask;
        logic                        read_channel;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  read_value;
        logic                        clipped;
    } out_beat_t;

    // Controls of the scaling pipeline
    typedef struct packed {
        logic load;
        logic step;
    } scale_ctl_t;

endpackage

// ===== design/gain_scaled_mix_accumulator_unit.sv =====
// Top level of the gain-scaled mix accumulator: command sequencer, saturation, registers.
`timescale 1ns / 1ps

// Mix bus accumulator with one buffer memory per channel.
// Input beats (s_valid/s_ready, s_data) carry a command: clear, accumulate or read.
// Every accepted beat gives exactly one result beat (m_valid/m_ready, m_data).
// Accumulate: the sample is scaled by the envelope gain and, when enabled, the
// master volume, then added with saturation into each masked channel slot.
// Read: returns one slot. Clear: zeroes every slot of every channel.
// Steps from acceptance to result valid with a free output register:
//   accumulate: second multiply, then saturating add and write back;
//   read: the read state; unknown command: the done state, result zero;
//   clear: one address of all channel memories per cycle over the buffer.
// s_ready rises in the same cycle as the result becomes valid.
// After reset the block runs a clearing pass over the whole buffer with s_ready
// low; the configuration port (cfg_we, cfg_addr, cfg_wdata) is always live.
// A result waits in the output register while the receiver stalls; a new beat
// is still accepted, and its result is parked until the output register frees.
module gain_scaled_mix_accumulator_unit #(
    parameter int BUFFER_SIZE = gsma_pkg::BUFFER_SIZE_DEF,
    parameter int CHANNELS    = gsma_pkg::CHANNELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  gsma_pkg::in_beat_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output gsma_pkg::out_beat_t                 m_data,
    input  logic                                cfg_we,
    input  logic [gsma_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gsma_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(BUFFER_SIZE);
    localparam int SW = gsma_pkg::SAMPLE_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLEAR = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_ADD   = 6'b001000,
        ST_READ  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic                            clr_cmd_reg, clr_cmd_next;
    logic [AW-1:0]                   clr_addr_reg, clr_addr_next;
    logic                            in_range_reg, in_range_next;
    logic [AW-1:0]                   pos_reg, pos_next;
    logic [gsma_pkg::MASK_W-1:0]     mask_reg, mask_next;
    logic                            rch_reg, rch_next;
    logic signed [SW-1:0]            res_value_reg, res_value_next;
    logic                            res_clip_reg, res_clip_next;
    logic                            m_valid_reg, m_valid_next;
    gsma_pkg::out_beat_t             m_data_reg, m_data_next;
    logic                            vol_en_reg;
    logic [gsma_pkg::GAIN_W-1:0]     master_vol_reg;

    logic                            accept;
    logic                            out_free;
    logic                            fin;
    logic signed [SW-1:0]            fin_value;
    logic                            fin_clip;
    logic                            mem_re;
    logic [AW-1:0]                   mem_raddr;
    logic [AW-1:0]                   mem_waddr;
    logic                            clear_last;
    logic [gsma_pkg::GAIN_W-1:0]     volume;
    gsma_pkg::scale_ctl_t            scale_ctl;
    logic signed [gsma_pkg::SCALED_W-1:0] scaled;
    logic signed [SW-1:0]            rdata_ch [CHANNELS];
    logic signed [SW-1:0]            sat_ch [CHANNELS];
    logic [CHANNELS-1:0]             clip_ch;
    logic [CHANNELS-1:0]             we_ch;
    logic signed [SW-1:0]            rd_sel;
    logic                            rd_ok;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_en_reg     <= 1'b0;
            master_vol_reg <= gsma_pkg::UNITY_GAIN;
        end else if (cfg_we) begin
            case (cfg_addr)
                gsma_pkg::CFG_VOLUME_ENABLE: vol_en_reg     <= cfg_wdata[0];
                gsma_pkg::CFG_MASTER_VOLUME: master_vol_reg <= cfg_wdata;
                default:                     vol_en_reg     <= vol_en_reg;
            endcase
        end
    end

    assign volume = vol_en_reg ? master_vol_reg : gsma_pkg::UNITY_GAIN;

    // Scaling pipeline: first product at acceptance, second in the multiply state
    assign scale_ctl.load = accept;
    assign scale_ctl.step = (state_reg == ST_MUL);

    gsma_scale u_scale (
        .aclk          (aclk),
        .ctl           (scale_ctl),
        .sample_in     (s_data.sample_in),
        .envelope_gain (s_data.envelope_gain),
        .volume        (volume),
        .scaled        (scaled)
    );

    // Memory addressing: read at acceptance, write back in the add state or sweep
    assign mem_re     = accept && (s_data.command == gsma_pkg::CMD_ACCUM ||
                                   s_data.command == gsma_pkg::CMD_READ);
    assign mem_raddr  = AW'(s_data.position);
    assign mem_waddr  = (state_reg == ST_CLEAR) ? clr_addr_reg : pos_reg;
    assign clear_last = (clr_addr_reg == AW'(BUFFER_SIZE - 1));

    // One buffer memory per channel, with its saturating adder
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        logic [SW-1:0]                    rdata_raw;
        logic signed [gsma_pkg::SUM_W-1:0] sum;
        logic [SW-1:0]                    wdata;

        always_comb begin
            rdata_ch[c] = $signed(rdata_raw);
            sum = gsma_pkg::SUM_W'(rdata_ch[c]) + gsma_pkg::SUM_W'(scaled);
            if (sum > gsma_pkg::SLOT_MAX) begin
                sat_ch[c]  = SW'(gsma_pkg::SLOT_MAX);
                clip_ch[c] = we_ch[c];
            end else if (sum < gsma_pkg::SLOT_MIN) begin
                sat_ch[c]  = SW'(gsma_pkg::SLOT_MIN);
                clip_ch[c] = we_ch[c];
            end else begin
                sat_ch[c]  = SW'(sum);
                clip_ch[c] = 1'b0;
            end
        end

        assign we_ch[c] = (state_reg == ST_CLEAR) ||
                          (state_reg == ST_ADD && in_range_reg && mask_reg[c]);
        assign wdata    = (state_reg == ST_CLEAR) ? '0 : sat_ch[c];

        gsma_ram #(
            .WIDTH (SW),
            .DEPTH (BUFFER_SIZE)
        ) u_ram (
            .aclk  (aclk),
            .we    (we_ch[c]),
            .waddr (mem_waddr),
            .wdata (wdata),
            .re    (mem_re),
            .raddr (mem_raddr),
            .rdata (rdata_raw)
        );
    end

    // Read select: a channel beyond the configured count reads as zero
    assign rd_sel = (rch_reg && CHANNELS > 1) ? rdata_ch[CHANNELS-1] : rdata_ch[0];
    assign rd_ok  = in_range_reg && (!rch_reg || CHANNELS > 1);

    // Command sequencer. Beats are taken only in idle and the write-back ends
    // before the next acceptance, so a read never overlaps a pending write.
    always_comb begin
        state_next     = state_reg;
        clr_cmd_next   = clr_cmd_reg;
        clr_addr_next  = clr_addr_reg;
        in_range_next  = in_range_reg;
        pos_next       = pos_reg;
        mask_next      = mask_reg;
        rch_next       = rch_reg;
        res_value_next = res_value_reg;
        res_clip_next  = res_clip_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        fin            = 1'b0;
        fin_value      = '0;
        fin_clip       = 1'b0;

        // Drop the output beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    in_range_next = (32'(s_data.position) < 32'(BUFFER_SIZE));
                    pos_next      = AW'(s_data.position);
                    mask_next     = s_data.channel_mask;
                    rch_next      = s_data.read_channel;
                    case (s_data.command)
                        gsma_pkg::CMD_CLEAR: begin
                            state_next    = ST_CLEAR;
                            clr_cmd_next  = 1'b1;
                            clr_addr_next = '0;
                        end
                        gsma_pkg::CMD_ACCUM: state_next = ST_MUL;
                        gsma_pkg::CMD_READ:  state_next = ST_READ;
                        default: begin
                            state_next     = ST_DONE;
                            res_value_next = '0;
                            res_clip_next  = 1'b0;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clear_last) begin
                    if (clr_cmd_reg) begin
                        fin = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                fin      = 1'b1;
                fin_clip = |clip_ch;
            end
            ST_READ: begin
                fin       = 1'b1;
                fin_value = rd_ok ? rd_sel : '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.read_value = res_value_reg;
                    m_data_next.clipped    = res_clip_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Deliver a finished result, or park it while the receiver stalls
        if (fin) begin
            if (out_free) begin
                m_valid_next           = 1'b1;
                m_data_next.read_value = fin_value;
                m_data_next.clipped    = fin_clip;
                state_next             = ST_IDLE;
            end else begin
                res_value_next = fin_value;
                res_clip_next  = fin_clip;
                state_next     = ST_DONE;
            end
        end
    end

    // Control registers: reset starts the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cmd_reg  <= 1'b0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cmd_reg  <= clr_cmd_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_range_reg  <= in_range_next;
        pos_reg       <= pos_next;
        mask_reg      <= mask_next;
        rch_reg       <= rch_next;
        res_value_reg <= res_value_next;
        res_clip_reg  <= res_clip_next;
        m_data_reg    <= m_data_next;
    end

`ifndef ASSERT_OFF
    // No buffer write while a beat is being accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (|we_ch) |-> !accept)
        else $error("buffer write overlaps an accepted beat");

    // The add state always follows the second multiply
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD) |-> ($past(state_reg) == ST_MUL))
        else $error("add state entered without the multiply stage");

    // A result parked after a stalled finish keeps the output register occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && $past(state_reg) != ST_IDLE) |-> m_valid_reg)
        else $error("result parked while output register is free");

    // A clearing sweep starts at the first address
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_CLEAR) |-> (clr_addr_reg == '0))
        else $error("clear sweep did not start at address zero");
`endif

endmodule

// ===== design/gsma_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module gsma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port: hold the last read word until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/gsma_scale.sv =====
// Two-stage multiplier pipeline that scales a sample by envelope and master gains.
`timescale 1ns / 1ps

module gsma_scale (
    input  logic                                  aclk,
    input  gsma_pkg::scale_ctl_t                  ctl,
    input  logic signed [gsma_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [gsma_pkg::GAIN_W-1:0]           envelope_gain,
    input  logic [gsma_pkg::GAIN_W-1:0]           volume,
    output logic signed [gsma_pkg::SCALED_W-1:0]  scaled
);

    localparam int MAG_W = gsma_pkg::PROD2_W - gsma_pkg::GAIN_FRAC_W;

    logic [gsma_pkg::SAMPLE_W-1:0] mag;
    logic [gsma_pkg::PROD1_W-1:0]  prod1_reg;
    logic [gsma_pkg::PROD2_W-1:0]  prod2_reg;
    logic                          neg_reg;
    logic [MAG_W-1:0]              scaled_mag;

    // Magnitude of the sample; the most negative value maps to 32768
    assign mag = sample_in[gsma_pkg::SAMPLE_W-1] ? gsma_pkg::SAMPLE_W'(-sample_in)
                                                 : gsma_pkg::SAMPLE_W'(sample_in);

    // First product: magnitude times envelope gain
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            prod1_reg <= mag * envelope_gain;
            neg_reg   <= sample_in[gsma_pkg::SAMPLE_W-1];
        end
    end

    // Second product: times master volume
    always_ff @(posedge aclk) begin
        if (ctl.step) begin
            prod2_reg <= prod1_reg * volume;
        end
    end

    // Drop the fraction bits and restore the sign (truncation toward zero)
    assign scaled_mag = prod2_reg[gsma_pkg::PROD2_W-1:gsma_pkg::GAIN_FRAC_W];
    assign scaled = neg_reg ? -$signed({1'b0, scaled_mag}) : $signed({1'b0, scaled_mag});

endmodule
